@@ design/bst_pkg.sv @@
`default_nettype none
package bst_pkg;

	localparam int NUM_CALLERS_DEF      = 16;
	localparam int SLOTS_PER_CALLER_DEF = 8;
	localparam int QUEUE_LAST_INDEX_DEF = 16;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_UP     = 2'd1;
	localparam logic [1:0] OP_DOWN   = 2'd2;
	localparam logic [1:0] OP_CLOSE  = 2'd3;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_ERR     = 2'd1;
	localparam logic [1:0] STS_SUSPEND = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         caller_id;
		logic signed [31:0] sem_descriptor;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] echo_descriptor;
		logic               wake_valid;
		logic [3:0]         wake_id;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_EXEC,
		S_QWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic cmp;
		logic exec;
		logic qfin;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic need_qwait;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ design/binary_semaphore_table.sv @@
`default_nettype none
// Binary semaphore table with FIFO wait queues. Each request (create, up, down,
// close) gives one response word. The caller's slots are scanned one at a time
// through the registered read port of the slot memory, a read state and then a
// compare state per slot, before the result is written to the result register;
// an up that wakes a waiter first reads the oldest waiter from its queue. The
// next request is taken once the previous response is in the output register.
module binary_semaphore_table #(
	parameter int NUM_CALLERS      = bst_pkg::NUM_CALLERS_DEF,
	parameter int SLOTS_PER_CALLER = bst_pkg::SLOTS_PER_CALLER_DEF,
	parameter int QUEUE_LAST_INDEX = bst_pkg::QUEUE_LAST_INDEX_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bst_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bst_pkg::rsp_t      rsp
);
	bst_pkg::cmd_t cmd;
	bst_pkg::sts_t sts;

	bst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.sts(sts), .cmd(cmd)
	);

	bst_dp #(
		.NUM_CALLERS(NUM_CALLERS),
		.SLOTS_PER_CALLER(SLOTS_PER_CALLER),
		.QUEUE_LAST_INDEX(QUEUE_LAST_INDEX)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);
endmodule
`default_nettype wire

@@ design/bst_ram.sv @@
`default_nettype none
module bst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/bst_ctrl.sv @@
`default_nettype none
module bst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bst_pkg::sts_t sts,
	output bst_pkg::cmd_t      cmd
);
	bst_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bst_pkg::S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			bst_pkg::S_IDLE:  if (req_valid) state_nx = bst_pkg::S_RD;
			bst_pkg::S_RD:    state_nx = bst_pkg::S_CMP;
			bst_pkg::S_CMP:   state_nx = sts.scan_last ? bst_pkg::S_EXEC : bst_pkg::S_RD;
			bst_pkg::S_EXEC:  state_nx = sts.need_qwait ? bst_pkg::S_QWAIT : bst_pkg::S_DONE;
			bst_pkg::S_QWAIT: state_nx = bst_pkg::S_DONE;
			bst_pkg::S_DONE:  if (sts.out_free) state_nx = bst_pkg::S_IDLE;
			default:          state_nx = bst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			bst_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			bst_pkg::S_RD:    cmd.rd = 1'b1;
			bst_pkg::S_CMP:   cmd.cmp = 1'b1;
			bst_pkg::S_EXEC:  cmd.exec = 1'b1;
			bst_pkg::S_QWAIT: cmd.qfin = 1'b1;
			bst_pkg::S_DONE:  cmd.load = sts.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ design/bst_dp.sv @@
`default_nettype none
module bst_dp #(
	parameter int NUM_CALLERS      = bst_pkg::NUM_CALLERS_DEF,
	parameter int SLOTS_PER_CALLER = bst_pkg::SLOTS_PER_CALLER_DEF,
	parameter int QUEUE_LAST_INDEX = bst_pkg::QUEUE_LAST_INDEX_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bst_pkg::req_t req,
	input  wire bst_pkg::cmd_t cmd,
	output bst_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bst_pkg::rsp_t      rsp
);
	localparam int CALLERS = NUM_CALLERS < 16 ? NUM_CALLERS : 16;
	localparam int SPC     = SLOTS_PER_CALLER;
	localparam int TOTAL   = CALLERS * SPC;
	localparam int QD      = QUEUE_LAST_INDEX + 1;
	localparam int SLOT_W  = TOTAL > 1 ? $clog2(TOTAL) : 1;
	localparam int POS_W   = SPC > 1 ? $clog2(SPC) : 1;
	localparam int QI_W    = $clog2(QD);
	localparam int CNT_W   = $clog2(QD + 1);
	localparam int QTOT    = TOTAL * QD;
	localparam int QA_W    = QTOT > 1 ? $clog2(QTOT) : 1;
	localparam int META_W  = 32 + 1 + 2 * QI_W + CNT_W;
	localparam logic [8:0] NC = 9'(NUM_CALLERS);

	bst_pkg::req_t req_q;
	logic          caller_ok_q;
	logic [POS_W-1:0] idx_q;
	logic          hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic [META_W-1:0] meta_q;
	logic [TOTAL-1:0]  used_q;
	bst_pkg::rsp_t res_q;

	logic [3:0]        caller_sel;
	logic [SLOT_W-1:0] base;
	logic [SLOT_W-1:0] scan_addr;
	logic [SPC-1:0]    used_row;
	logic              free_found;
	logic [POS_W-1:0]  free_pos;
	logic [META_W-1:0] meta_rd;

	logic              meta_we;
	logic [META_W-1:0] meta_wdata;
	logic [SLOT_W-1:0] meta_waddr;
	logic              q_we, q_re;
	logic [QA_W-1:0]   q_waddr, q_raddr;
	logic [3:0]        q_rdata;
	logic              used_set, used_clr;
	logic [SLOT_W-1:0] used_idx;
	bst_pkg::rsp_t     res_nx;
	logic              res_ld;

	logic [31:0]       m_desc;
	logic              m_val;
	logic [QI_W-1:0]   m_head, m_tail, h_nx, t_nx;
	logic [CNT_W-1:0]  m_cnt;

	assign caller_sel = caller_ok_q ? req_q.caller_id : 4'd0;
	assign base       = SLOT_W'(32'(caller_sel) * SPC);
	assign scan_addr  = base + SLOT_W'(idx_q);
	assign used_row   = used_q[base +: SPC];

	always_comb begin
		free_found = 1'b0;
		free_pos   = '0;
		for (int i = SPC - 1; i >= 0; i--) begin
			if (!used_row[i]) begin
				free_found = 1'b1;
				free_pos   = POS_W'(i);
			end
		end
	end

	assign m_desc = meta_q[META_W-1 -: 32];
	assign m_val  = meta_q[CNT_W + 2 * QI_W];
	assign m_head = meta_q[CNT_W + QI_W +: QI_W];
	assign m_tail = meta_q[CNT_W +: QI_W];
	assign m_cnt  = meta_q[CNT_W-1:0];
	assign h_nx   = (m_head == QI_W'(QUEUE_LAST_INDEX)) ? '0 : m_head + 1'b1;
	assign t_nx   = (m_tail == QI_W'(QUEUE_LAST_INDEX)) ? '0 : m_tail + 1'b1;

	assign sts.scan_last  = (idx_q == POS_W'(SPC - 1));
	assign sts.need_qwait = caller_ok_q && hit_q && req_q.operation == bst_pkg::OP_UP
		&& !m_val && m_cnt != '0;
	assign sts.out_free   = !rsp_valid || rsp_ready;

	bst_ram #(.WIDTH(META_W), .DEPTH(TOTAL)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.re(cmd.rd), .raddr(scan_addr), .rdata(meta_rd)
	);

	bst_ram #(.WIDTH(4), .DEPTH(QTOT)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(req_q.caller_id),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = slot_q;
		meta_wdata = meta_q;
		q_we       = 1'b0;
		q_re       = 1'b0;
		q_waddr    = QA_W'(slot_q) * QA_W'(QD) + QA_W'(m_tail);
		q_raddr    = QA_W'(slot_q) * QA_W'(QD) + QA_W'(m_head);
		used_set   = 1'b0;
		used_clr   = 1'b0;
		used_idx   = slot_q;
		res_ld     = 1'b0;
		res_nx     = '{status: bst_pkg::STS_ERR, echo_descriptor: '0,
			wake_valid: 1'b0, wake_id: 4'd0};
		if (cmd.exec) begin
			res_ld = !sts.need_qwait;
			q_re   = sts.need_qwait;
			if (caller_ok_q) begin
				case (req_q.operation)
					bst_pkg::OP_CREATE: begin
						if (!hit_q && free_found) begin
							meta_we    = 1'b1;
							meta_waddr = base + SLOT_W'(free_pos);
							meta_wdata = {req_q.sem_descriptor, 1'b1, {QI_W{1'b0}},
								{QI_W{1'b0}}, {CNT_W{1'b0}}};
							used_set   = 1'b1;
							used_idx   = base + SLOT_W'(free_pos);
							res_nx.status          = bst_pkg::STS_OK;
							res_nx.echo_descriptor = req_q.sem_descriptor;
						end
					end
					bst_pkg::OP_UP: begin
						if (hit_q && !m_val && m_cnt == '0) begin
							meta_we    = 1'b1;
							meta_wdata = {m_desc, 1'b1, m_head, m_tail, m_cnt};
							res_nx.status = bst_pkg::STS_OK;
						end
					end
					bst_pkg::OP_DOWN: begin
						if (hit_q && m_val) begin
							meta_we    = 1'b1;
							meta_wdata = {m_desc, 1'b0, m_head, m_tail, m_cnt};
							res_nx.status = bst_pkg::STS_OK;
						end else if (hit_q && m_cnt < CNT_W'(QD)) begin
							q_we       = 1'b1;
							meta_we    = 1'b1;
							meta_wdata = {m_desc, 1'b0, m_head, t_nx, m_cnt + 1'b1};
							res_nx.status = bst_pkg::STS_SUSPEND;
						end
					end
					bst_pkg::OP_CLOSE: begin
						if (hit_q) begin
							used_clr      = 1'b1;
							res_nx.status = bst_pkg::STS_OK;
						end
					end
					default: ;
				endcase
			end
		end else if (cmd.qfin) begin
			// oldest waiter leaves the queue, value stays taken
			meta_we    = 1'b1;
			meta_wdata = {m_desc, 1'b0, h_nx, m_tail, m_cnt - 1'b1};
			res_ld     = 1'b1;
			res_nx.status     = bst_pkg::STS_OK;
			res_nx.wake_valid = 1'b1;
			res_nx.wake_id    = q_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q       <= req;
			caller_ok_q <= {5'd0, req.caller_id} < NC;
		end
		if (cmd.cmp && used_q[scan_addr] && meta_rd[META_W-1 -: 32] == req_q.sem_descriptor)
		begin
			slot_q <= scan_addr;
			meta_q <= meta_rd;
		end
		if (res_ld)
			res_q <= res_nx;
		if (cmd.load)
			rsp <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			hit_q     <= 1'b0;
			used_q    <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.cmp) begin
				if (!sts.scan_last)
					idx_q <= idx_q + 1'b1;
				if (used_q[scan_addr] && meta_rd[META_W-1 -: 32] == req_q.sem_descriptor)
					hit_q <= 1'b1;
			end
			if (used_set)
				used_q[used_idx] <= 1'b1;
			if (used_clr)
				used_q[used_idx] <= 1'b0;
			if (cmd.load)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire
